### design/tnfc_pkg.sv
// ----------------------------------------------------------------------------
// tnfc_pkg: shared types and constants of the triangle near/far clipper
// Vertex and triangle types, outcodes, back end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tnfc_pkg;

	localparam int ATTR_W = 32;
	localparam int NATTR  = 9;
	localparam int TBITS  = 62 - ATTR_W;
	localparam int MAXV   = 5;

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// attribute slots of a vertex
	localparam int A_X  = 0;
	localparam int A_Y  = 1;
	localparam int A_Z  = 2;
	localparam int A_W  = 3;
	localparam int A_NX = 4;
	localparam int A_NY = 5;
	localparam int A_NZ = 6;
	localparam int A_U  = 7;
	localparam int A_V  = 8;

	localparam logic [1:0] CODE_NONE = 2'b00;
	localparam logic [1:0] CODE_FAR  = 2'b01;
	localparam logic [1:0] CODE_NEAR = 2'b10;
	localparam logic [1:0] CODE_BOTH = 2'b11;

	typedef logic [NATTR-1:0][ATTR_W-1:0] vtx_t;

	typedef struct packed {
		vtx_t [2:0]       v;
		logic [2:0][1:0]  code;
	} tri_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_CORNER,
		BK_PLAN,
		BK_PREP,
		BK_CHECK,
		BK_DIV,
		BK_DIFF,
		BK_MUL,
		BK_ADD,
		BK_EMIT,
		BK_FLUSH
	} back_state_t;

	function automatic logic signed [ATTR_W:0] sx(input logic [ATTR_W-1:0] a);
		sx = $signed({a[ATTR_W-1], a});
	endfunction

endpackage

`default_nettype wire

### design/tnfc_front.sv
// ----------------------------------------------------------------------------
// tnfc_front: corner collection and triangle classification
// Holds two corners, culls on the third and pushes survivors to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tnfc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tnfc_pkg::vtx_t     in_vtx,
	input  wire logic               q_full,
	output logic                    push_valid,
	output tnfc_pkg::tri_t          push_tri
);

	logic [1:0]            cnt_q;
	tnfc_pkg::vtx_t [1:0]  hold_q;
	logic                  accept;
	logic                  culled;
	logic [2:0]            xl, xh, yl, yh;

	assign in_stall = (cnt_q == 2'd2) && q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		logic signed [tnfc_pkg::ATTR_W:0] x, y, z, w, nw;
		x = '0;
		y = '0;
		z = '0;
		w = '0;
		nw = '0;
		push_tri.v[0] = hold_q[0];
		push_tri.v[1] = hold_q[1];
		push_tri.v[2] = in_vtx;
		for (int k = 0; k < 3; k++) begin
			x  = tnfc_pkg::sx(push_tri.v[k][tnfc_pkg::A_X]);
			y  = tnfc_pkg::sx(push_tri.v[k][tnfc_pkg::A_Y]);
			z  = tnfc_pkg::sx(push_tri.v[k][tnfc_pkg::A_Z]);
			w  = tnfc_pkg::sx(push_tri.v[k][tnfc_pkg::A_W]);
			nw = -w;
			xl[k] = x < nw;
			xh[k] = x > w;
			yl[k] = y < nw;
			yh[k] = y > w;
			if (z < nw)
				push_tri.code[k] = tnfc_pkg::CODE_NEAR;
			else if (z > w)
				push_tri.code[k] = tnfc_pkg::CODE_FAR;
			else
				push_tri.code[k] = tnfc_pkg::CODE_NONE;
		end
		culled = (&xl) || (&xh) || (&yl) || (&yh)
			|| ((push_tri.code[0] & push_tri.code[1] & push_tri.code[2]) != 2'b00);
	end

	assign push_valid = accept && (cnt_q == 2'd2) && !culled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cnt_q != 2'd2)
			hold_q[cnt_q[0]] <= in_vtx;
	end

endmodule

`default_nettype wire

### design/tnfc_queue.sv
// ----------------------------------------------------------------------------
// tnfc_queue: two-entry triangle queue
// Decouples classification from clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module tnfc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tnfc_pkg::tri_t  push_tri,
	input  wire logic            pop,
	output logic                 full,
	output logic                 not_empty,
	output tnfc_pkg::tri_t       head
);

	tnfc_pkg::tri_t [1:0] mem_q;
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_tri;
	end

endmodule

`default_nettype wire

### design/tnfc_back.sv
// ----------------------------------------------------------------------------
// tnfc_back: edge clipping sequencer and screen mapping
// Walks the edges, divides for t, lerps attributes, emits mapped vertices.
// ----------------------------------------------------------------------------
`default_nettype none

module tnfc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire tnfc_pkg::tri_t  q_tri,
	output logic                 q_pop,
	input  wire logic [12:0]     half_w,
	input  wire logic [12:0]     half_h,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output tnfc_pkg::vtx_t       out_vtx,
	output logic                 out_last
);

	localparam int AW = tnfc_pkg::ATTR_W;
	localparam int TB = tnfc_pkg::TBITS;
	localparam int WW = AW + 4;

	tnfc_pkg::back_state_t state_q, state_d;

	logic [1:0]               edge_q, nx;
	logic [1:0]               xing_q;
	logic [2:0]               n_q;
	logic [3:0]               ai_q;
	logic [4:0]               dcnt_q;
	logic signed [WW-1:0]     n_raw_q, m_raw_q, nf_q, mf_q;
	logic [WW-1:0]            rem_q;
	logic [TB:0]              t_q;
	logic [AW:0]              mag_q;
	logic                     neg_q;
	logic [63:0]              prod_q;
	tnfc_pkg::vtx_t           cr_q, pend_q;
	logic                     pend_valid_q;
	logic                     out_valid_q;

	logic [1:0]               cp, cq, both, plane, first;
	logic                     skip;
	logic                     out_free, can_push, push_en, store, flush_load;
	logic                     near_sel, div_done;
	tnfc_pkg::vtx_t           new_v, map_src, mapped;
	logic signed [WW-1:0]     da, db, n_raw, m_raw;
	logic [WW-1:0]            r2;

	assign nx = (edge_q == 2'd2) ? 2'd0 : edge_q + 2'd1;
	assign cp = q_tri.code[edge_q];
	assign cq = q_tri.code[nx];
	assign both = cp | cq;
	assign first = (both == tnfc_pkg::CODE_BOTH && cp == tnfc_pkg::CODE_FAR)
		? tnfc_pkg::CODE_FAR : tnfc_pkg::CODE_NEAR;
	assign plane = (both == tnfc_pkg::CODE_BOTH)
		? ((xing_q == 2'd0) ? first : (first ^ tnfc_pkg::CODE_BOTH)) : both;
	assign skip = (cp == cq)
		|| (xing_q >= ((both == tnfc_pkg::CODE_BOTH) ? 2'd2 : 2'd1));
	assign near_sel = plane == tnfc_pkg::CODE_NEAR;
	assign div_done = dcnt_q == 5'd1;

	assign out_free = !out_valid_q || !out_stall;
	assign can_push = !pend_valid_q || out_free;
	assign out_valid = out_valid_q;

	// plane distances of the edge end points
	always_comb begin
		logic signed [WW-1:0] za, wa, zb, wb;
		za = WW'(tnfc_pkg::sx(q_tri.v[edge_q][tnfc_pkg::A_Z]));
		wa = WW'(tnfc_pkg::sx(q_tri.v[edge_q][tnfc_pkg::A_W]));
		zb = WW'(tnfc_pkg::sx(q_tri.v[nx][tnfc_pkg::A_Z]));
		wb = WW'(tnfc_pkg::sx(q_tri.v[nx][tnfc_pkg::A_W]));
		if (near_sel) begin
			da = za + wa;
			db = zb + wb;
			n_raw = -da;
			m_raw = db - da;
		end else begin
			da = wa - za;
			db = wb - zb;
			n_raw = da;
			m_raw = da - db;
		end
	end

	assign r2 = {rem_q[WW-2:0], 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tnfc_pkg::BK_IDLE:
				if (q_valid)
					state_d = tnfc_pkg::BK_CORNER;
			tnfc_pkg::BK_CORNER:
				if (cp != tnfc_pkg::CODE_NONE || can_push)
					state_d = tnfc_pkg::BK_PLAN;
			tnfc_pkg::BK_PLAN:
				if (!skip)
					state_d = tnfc_pkg::BK_PREP;
				else if (edge_q == 2'd2)
					state_d = tnfc_pkg::BK_FLUSH;
				else
					state_d = tnfc_pkg::BK_CORNER;
			tnfc_pkg::BK_PREP:
				state_d = tnfc_pkg::BK_CHECK;
			tnfc_pkg::BK_CHECK:
				if (mf_q == '0 || nf_q <= 0 || nf_q >= mf_q)
					state_d = tnfc_pkg::BK_DIFF;
				else
					state_d = tnfc_pkg::BK_DIV;
			tnfc_pkg::BK_DIV:
				if (div_done)
					state_d = tnfc_pkg::BK_DIFF;
			tnfc_pkg::BK_DIFF:
				state_d = tnfc_pkg::BK_MUL;
			tnfc_pkg::BK_MUL:
				state_d = tnfc_pkg::BK_ADD;
			tnfc_pkg::BK_ADD:
				state_d = (ai_q == 4'(tnfc_pkg::NATTR - 1))
					? tnfc_pkg::BK_EMIT : tnfc_pkg::BK_DIFF;
			tnfc_pkg::BK_EMIT:
				if (can_push)
					state_d = tnfc_pkg::BK_PLAN;
			tnfc_pkg::BK_FLUSH:
				if (!pend_valid_q || out_free)
					state_d = tnfc_pkg::BK_IDLE;
			default:
				state_d = tnfc_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		push_en = 1'b0;
		flush_load = 1'b0;
		q_pop = 1'b0;
		new_v = cr_q;
		unique case (state_q)
			tnfc_pkg::BK_CORNER: begin
				new_v = q_tri.v[edge_q];
				push_en = (cp == tnfc_pkg::CODE_NONE) && can_push;
			end
			tnfc_pkg::BK_EMIT:
				push_en = can_push;
			tnfc_pkg::BK_FLUSH: begin
				flush_load = pend_valid_q && out_free;
				q_pop = !pend_valid_q || out_free;
			end
			default: ;
		endcase
	end

	assign store = push_en && (n_q < 3'(tnfc_pkg::MAXV));
	assign map_src = pend_q;

	// screen mapping of the vertex leaving the pending slot
	always_comb begin
		logic signed [AW:0]    sx_sum, sy_sum;
		logic signed [AW+14:0] px, py;
		sx_sum = tnfc_pkg::sx(map_src[tnfc_pkg::A_X]) + tnfc_pkg::sx(map_src[tnfc_pkg::A_W]);
		sy_sum = tnfc_pkg::sx(map_src[tnfc_pkg::A_Y]) + tnfc_pkg::sx(map_src[tnfc_pkg::A_W]);
		px = $signed({1'b0, half_w}) * sx_sum;
		py = $signed({1'b0, half_h}) * sy_sum;
		mapped = map_src;
		if (px > $signed({{15{1'b0}}, 1'b0, {(AW-1){1'b1}}}))
			mapped[tnfc_pkg::A_X] = {1'b0, {(AW-1){1'b1}}};
		else if (px < $signed({{15{1'b1}}, 1'b1, {(AW-1){1'b0}}}))
			mapped[tnfc_pkg::A_X] = {1'b1, {(AW-1){1'b0}}};
		else
			mapped[tnfc_pkg::A_X] = px[AW-1:0];
		if (py > $signed({{15{1'b0}}, 1'b0, {(AW-1){1'b1}}}))
			mapped[tnfc_pkg::A_Y] = {1'b0, {(AW-1){1'b1}}};
		else if (py < $signed({{15{1'b1}}, 1'b1, {(AW-1){1'b0}}}))
			mapped[tnfc_pkg::A_Y] = {1'b1, {(AW-1){1'b0}}};
		else
			mapped[tnfc_pkg::A_Y] = py[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnfc_pkg::BK_IDLE;
			edge_q <= 2'd0;
			xing_q <= 2'd0;
			n_q <= 3'd0;
			ai_q <= 4'd0;
			dcnt_q <= 5'd0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tnfc_pkg::BK_IDLE) begin
				edge_q <= 2'd0;
				xing_q <= 2'd0;
				n_q <= 3'd0;
			end
			if (state_q == tnfc_pkg::BK_PLAN && skip && edge_q != 2'd2) begin
				edge_q <= edge_q + 2'd1;
				xing_q <= 2'd0;
			end
			if (state_q == tnfc_pkg::BK_EMIT && can_push)
				xing_q <= xing_q + 2'd1;
			if (state_q == tnfc_pkg::BK_CHECK) begin
				ai_q <= 4'd0;
				dcnt_q <= 5'(TB);
			end
			if (state_q == tnfc_pkg::BK_DIV)
				dcnt_q <= dcnt_q - 5'd1;
			if (state_q == tnfc_pkg::BK_ADD)
				ai_q <= ai_q + 4'd1;
			if (store) begin
				n_q <= n_q + 3'd1;
				pend_valid_q <= 1'b1;
			end else if (flush_load) begin
				pend_valid_q <= 1'b0;
			end
			if ((store && pend_valid_q) || flush_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tnfc_pkg::BK_PLAN) begin
			n_raw_q <= n_raw;
			m_raw_q <= m_raw;
		end
		if (state_q == tnfc_pkg::BK_PREP) begin
			nf_q <= m_raw_q[WW-1] ? -n_raw_q : n_raw_q;
			mf_q <= m_raw_q[WW-1] ? -m_raw_q : m_raw_q;
		end
		if (state_q == tnfc_pkg::BK_CHECK) begin
			rem_q <= nf_q;
			if (mf_q == '0 || nf_q <= 0)
				t_q <= '0;
			else if (nf_q >= mf_q)
				t_q <= {1'b1, {TB{1'b0}}};
			else
				t_q <= '0;
		end
		if (state_q == tnfc_pkg::BK_DIV) begin
			if (r2 >= mf_q) begin
				rem_q <= r2 - mf_q;
				t_q <= {t_q[TB-1:0], 1'b1};
			end else begin
				rem_q <= r2;
				t_q <= {t_q[TB-1:0], 1'b0};
			end
		end
		if (state_q == tnfc_pkg::BK_DIFF) begin : diff_blk
			logic signed [AW:0] d;
			d = tnfc_pkg::sx(q_tri.v[nx][ai_q]) - tnfc_pkg::sx(q_tri.v[edge_q][ai_q]);
			neg_q <= d[AW];
			mag_q <= d[AW] ? -d : d;
		end
		if (state_q == tnfc_pkg::BK_MUL)
			prod_q <= 64'(mag_q) * 64'(t_q);
		if (state_q == tnfc_pkg::BK_ADD) begin : add_blk
			logic [63:0]        rnd;
			logic signed [AW+1:0] a, q, r;
			rnd = prod_q + (64'd1 << (TB - 1));
			q = $signed({2'b00, rnd[TB+AW-1:TB]});
			a = (AW+2)'(tnfc_pkg::sx(q_tri.v[edge_q][ai_q]));
			r = neg_q ? a - q : a + q;
			cr_q[ai_q] <= r[AW-1:0];
		end
		if (store)
			pend_q <= new_v;
		if ((store && pend_valid_q) || flush_load) begin
			out_vtx <= mapped;
			out_last <= flush_load;
		end
	end

endmodule

`default_nettype wire

### design/triangle_near_far_clipper.sv
// ----------------------------------------------------------------------------
// triangle_near_far_clipper: homogeneous triangle near/far clipper
// Collects three corners, culls, clips against z=-w and z=w, maps to screen.
// ----------------------------------------------------------------------------
// Vertices enter one per transaction; every third vertex closes a triangle.
// The front end holds the first two corners and, on the closing vertex,
// drops the triangle when all corners lie past one x/y side or share a
// near/far outcode; a survivor goes into a two-triangle queue, and the input
// stalls only while that queue is full. The back end walks the three edges:
// a corner step per corner, a plan step per edge decision and, per plane
// crossing, the one-bit-a-cycle divider for t and the single shared
// multiplier that lerps the nine attributes in difference, multiply and add
// steps. Result vertices leave through a one-deep pending slot and an output
// register, so the final vertex carries last_vertex and the back end keeps
// working while a result waits to be taken.
`default_nettype none

module triangle_near_far_clipper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [13:0] cfg_data,
	// vertex input
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	input  wire logic [31:0] pos_w,
	input  wire logic [31:0] norm_x,
	input  wire logic [31:0] norm_y,
	input  wire logic [31:0] norm_z,
	input  wire logic [31:0] tex_u,
	input  wire logic [31:0] tex_v,
	// vertex output
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [31:0]      out_z,
	output logic [31:0]      out_w,
	output logic [31:0]      out_nx,
	output logic [31:0]      out_ny,
	output logic [31:0]      out_nz,
	output logic [31:0]      out_u,
	output logic [31:0]      out_v,
	output logic             last_vertex
);

	logic [13:0]     width_q, height_q;
	tnfc_pkg::vtx_t  in_vtx, res_vtx;
	tnfc_pkg::tri_t  push_tri, head_tri;
	logic            push_valid, q_full, q_not_empty, q_pop;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd640;
			height_q <= 14'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tnfc_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				tnfc_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pack the input fields into attribute slots
	always_comb begin
		in_vtx[tnfc_pkg::A_X]  = pos_x;
		in_vtx[tnfc_pkg::A_Y]  = pos_y;
		in_vtx[tnfc_pkg::A_Z]  = pos_z;
		in_vtx[tnfc_pkg::A_W]  = pos_w;
		in_vtx[tnfc_pkg::A_NX] = norm_x;
		in_vtx[tnfc_pkg::A_NY] = norm_y;
		in_vtx[tnfc_pkg::A_NZ] = norm_z;
		in_vtx[tnfc_pkg::A_U]  = tex_u;
		in_vtx[tnfc_pkg::A_V]  = tex_v;
	end

	// collect corners and classify the triangle
	tnfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_vtx     (in_vtx),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_tri   (push_tri)
	);

	// hold surviving triangles between the two halves
	tnfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_tri  (push_tri),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_tri)
	);

	// clip, interpolate and map; halves of the viewport drop the low bit
	tnfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_tri     (head_tri),
		.q_pop     (q_pop),
		.half_w    (width_q[13:1]),
		.half_h    (height_q[13:1]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_vtx   (res_vtx),
		.out_last  (last_vertex)
	);

	assign out_x  = res_vtx[tnfc_pkg::A_X];
	assign out_y  = res_vtx[tnfc_pkg::A_Y];
	assign out_z  = res_vtx[tnfc_pkg::A_Z];
	assign out_w  = res_vtx[tnfc_pkg::A_W];
	assign out_nx = res_vtx[tnfc_pkg::A_NX];
	assign out_ny = res_vtx[tnfc_pkg::A_NY];
	assign out_nz = res_vtx[tnfc_pkg::A_NZ];
	assign out_u  = res_vtx[tnfc_pkg::A_U];
	assign out_v  = res_vtx[tnfc_pkg::A_V];

endmodule

`default_nettype wire
